// ----- rtl/fswt_pkg.sv -----
// fswt_pkg: shared types and constants for the frequency sorted weighted table
// holds beat structs, table entry layout, command and status codes
// no dependencies
package fswt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W       = 32;
  localparam int ENTRY_W     = KEY_WIDTH + CNT_W;

  localparam logic [CNT_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_PICK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] draw;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
    logic [31:0] picked_key;
    logic [31:0] total_count;
  } res_beat_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     count;
  } entry_t;

endpackage

// ----- rtl/fswt_ram.sv -----
// fswt_ram: generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module fswt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/frequency_sorted_weighted_table_core.sv -----
// Frequency sorted weighted table. Holds up to TABLE_DEPTH (key, count) entries in one
// ram, kept in descending count order, plus the running total. Add, lookup and pick
// each scan the table from the head, one entry per cycle through the ram read port; an
// add that raises a count then shifts the run of equal counts down one entry per cycle
// through the same port. An empty pick or an unused code skips the scan and goes
// straight to FIN; the longest is an add that moves the last entry to the head. One
// command is in flight at a time; its result waits in the output register while the
// next command is taken. No clearing pass is needed after reset.
// depends on fswt_pkg and fswt_ram
module frequency_sorted_weighted_table_core
  import fswt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_beat_t cmd_beat,
  output logic      res_valid,
  input  logic      res_ready,
  output res_beat_t res_beat
);

  typedef enum logic [1:0] {IDLE, SCAN, SHIFT, FIN} state_t;

  state_t               state;
  logic [USED_W-1:0]    used;
  logic [CNT_W-1:0]     sum;
  logic [1:0]           cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]     rem;
  logic [USED_W-1:0]    rd_idx;
  logic                 data_v;
  logic [IDX_W-1:0]     data_idx;
  logic [CNT_W-1:0]     prev_cnt;
  logic [IDX_W-1:0]     run_start;
  logic [IDX_W-1:0]     dst;
  logic [CNT_W-1:0]     new_cnt;
  res_beat_t            res_r;

  entry_t               rd_entry;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [USED_W-1:0]    rd_prev;
  logic [IDX_W-1:0]     run_start_eff;
  logic                 scan_hit;
  logic                 scan_miss;
  logic                 scan_issue;
  logic                 shift_issue;
  logic                 shift_last;
  logic                 insert_ok;
  logic                 cmd_fire;
  logic                 out_free;

  assign rd_entry  = entry_t'(ram_rdata);
  assign rd_prev   = rd_idx - 1'b1;
  assign cmd_ready = (state == IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;

  assign run_start_eff = (data_idx == '0 || rd_entry.count != prev_cnt) ? data_idx : run_start;

  assign scan_hit = (state == SCAN) && data_v &&
                    ((cmd_r == CMD_PICK) ? (rem < rd_entry.count) : (rd_entry.key == key_r));
  assign scan_miss   = (state == SCAN) && !data_v && (rd_idx >= used);
  assign scan_issue  = (state == SCAN) && !scan_hit && (rd_idx < used);
  assign shift_issue = (state == SHIFT) && (rd_idx > {1'b0, dst});
  assign shift_last  = (state == SHIFT) && !data_v && (rd_idx == {1'b0, dst});
  assign insert_ok   = (cmd_r == CMD_ADD) && (sum != SUM_MAX) &&
                       (used < USED_W'(TABLE_DEPTH));

  always_comb begin
    ram_raddr = (state == SHIFT) ? rd_prev[IDX_W-1:0] : rd_idx[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = data_idx + 1'b1;
    ram_wdata = rd_entry;
    if (scan_miss && insert_ok) begin
      ram_we    = 1'b1;
      ram_waddr = used[IDX_W-1:0];
      ram_wdata = '{key: key_r, count: CNT_W'(1)};
    end else if (state == SHIFT && data_v) begin
      ram_we = 1'b1;
    end else if (shift_last) begin
      ram_we    = 1'b1;
      ram_waddr = dst;
      ram_wdata = '{key: key_r, count: new_cnt};
    end
  end

  fswt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      used      <= '0;
      sum       <= '0;
      data_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      data_v   <= scan_issue || shift_issue;
      data_idx <= ram_raddr;
      if (state == FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd_fire) begin
            cmd_r  <= cmd_beat.cmd;
            key_r  <= KEY_WIDTH'(cmd_beat.key);
            rem    <= cmd_beat.draw;
            rd_idx <= '0;
            if (cmd_beat.cmd == CMD_ADD || cmd_beat.cmd == CMD_LOOKUP ||
                (cmd_beat.cmd == CMD_PICK && used != '0 && cmd_beat.draw < sum)) begin
              res_r <= '{status: ST_OK, count: '0, picked_key: '0, total_count: '0};
              state <= SCAN;
            end else begin
              res_r <= '{status: ST_EMPTY, count: '0, picked_key: '0, total_count: '0};
              state <= FIN;
            end
          end
        end
        SCAN: begin
          if (scan_issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (data_v) begin
            prev_cnt  <= rd_entry.count;
            run_start <= run_start_eff;
            if (cmd_r == CMD_PICK && !scan_hit) begin
              rem <= rem - rd_entry.count;
            end
          end
          if (scan_hit) begin
            case (cmd_r)
              CMD_PICK: begin
                res_r.picked_key <= 32'(rd_entry.key);
                state            <= FIN;
              end
              CMD_LOOKUP: begin
                res_r.count <= rd_entry.count;
                state       <= FIN;
              end
              default: begin
                if (sum == SUM_MAX) begin
                  res_r.status <= ST_SAT;
                  res_r.count  <= rd_entry.count;
                  state        <= FIN;
                end else begin
                  new_cnt     <= rd_entry.count + 1'b1;
                  res_r.count <= rd_entry.count + 1'b1;
                  sum         <= sum + 1'b1;
                  dst         <= run_start_eff;
                  rd_idx      <= {1'b0, data_idx};
                  state       <= SHIFT;
                end
              end
            endcase
          end else if (scan_miss) begin
            state <= FIN;
            if (cmd_r != CMD_ADD) begin
              res_r.status <= ST_EMPTY;
            end else if (sum == SUM_MAX) begin
              res_r.status <= ST_SAT;
            end else if (!insert_ok) begin
              res_r.status <= ST_FULL;
            end else begin
              used        <= used + 1'b1;
              sum         <= sum + 1'b1;
              res_r.count <= CNT_W'(1);
            end
          end
        end
        SHIFT: begin
          if (shift_issue) begin
            rd_idx <= rd_prev;
          end
          if (shift_last) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            res_beat <= '{status: res_r.status, count: res_r.count,
                          picked_key: res_r.picked_key, total_count: sum};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/fswt_checker.sv -----
// fswt_checker: port level assertions for the frequency sorted weighted table
// bound to frequency_sorted_weighted_table_core; depends on fswt_pkg
module fswt_checker
  import fswt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input cmd_beat_t cmd_beat,
  input logic      res_valid,
  input logic      res_ready,
  input res_beat_t res_beat
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_beat))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous command in flight");

  a_sat_total: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_beat.status == ST_SAT |-> res_beat.total_count == SUM_MAX)
    else $error("saturation reported below full total");

  a_count_le_total: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_beat.status == ST_OK |-> res_beat.count <= res_beat.total_count)
    else $error("key count exceeds total");

  a_full_no_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_beat.status == ST_FULL || res_beat.status == ST_EMPTY)
      |-> res_beat.count == '0)
    else $error("count reported with full or not found status");

endmodule

bind frequency_sorted_weighted_table_core fswt_checker u_fswt_checker (.*);
